@@ rtl/pixel_to_draw_command_encoder_assert.svh @@
// Assertion macros for the pixel to draw-command encoder.
// Included by the port checker; depends on nothing else.
`ifndef PIXEL_TO_DRAW_COMMAND_ENCODER_ASSERT_SVH
`define PIXEL_TO_DRAW_COMMAND_ENCODER_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PDCE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds while reset is asserted.
`define PDCE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ rtl/pdce_pkg.sv @@
// Shared types and constants of the pixel to draw-command encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package pdce_pkg;

  // Coordinate width default and the widest coordinate the design supports.
  localparam int COORD_BITS_DEF = 8;
  localparam int COORD_BITS_MAX = 12;
  // A difference of two widest coordinates with sign and margin.
  localparam int DIFF_BITS = COORD_BITS_MAX + 2;
  // Depth of the job queue between front and back.
  localparam int Q_DEPTH = 2;

  // Command opcodes in bits 7..6 of a command word.
  typedef enum logic [1:0] {
    OPC_DX   = 2'd0,
    OPC_DY   = 2'd1,
    OPC_TOOL = 2'd2,
    OPC_DATA = 2'd3
  } opc_t;

  // Tool operands.
  localparam logic [5:0] TOOL_COLOUR  = 6'd3;
  localparam logic [5:0] TOOL_TARGETX = 6'd4;
  localparam logic [5:0] TOOL_TARGETY = 6'd5;

  typedef logic [7:0] cmd_t;

  localparam cmd_t CMD_LAST   = {OPC_DY, 6'd0};
  localparam cmd_t CMD_COLOUR = {OPC_TOOL, TOOL_COLOUR};

  // Up to three prepared command words for one axis move.
  typedef struct packed {
    logic [1:0]     cnt;
    cmd_t [2:0]     cmd;
  } axis_job_t;

  // Everything the back end needs to emit the words of one pixel.
  typedef struct packed {
    axis_job_t  y;
    axis_job_t  x;
    logic [2:0] g_cnt;
    logic [7:0] grey;
  } pixel_job_t;

endpackage

`default_nettype wire

@@ rtl/pdce_front.sv @@
// Front end: accepts pixels, tracks pen position and grey level, and plans the moves.
// Depends on pdce_pkg.
`default_nettype none

module pdce_front
  import pdce_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_x,
  input  wire logic [7:0] in_y,
  input  wire logic [7:0] in_colour,
  input  wire logic       q_full,
  output logic            push,
  output pixel_job_t      job
);

  localparam int IN_BITS = (COORD_BITS > 8) ? COORD_BITS : 8;

  logic [COORD_BITS-1:0] tx_r, tx_nxt;
  logic [COORD_BITS-1:0] ty_r, ty_nxt;
  logic [7:0]            grey_r, grey_nxt;
  logic [IN_BITS-1:0]    x_ext, y_ext;
  logic [COORD_BITS-1:0] want_x, want_y;

  // Plan the words that move one axis from cur to want.
  function automatic axis_job_t axis_plan(
    input logic [COORD_BITS_MAX-1:0] want,
    input logic [COORD_BITS_MAX-1:0] cur,
    input opc_t                      opc,
    input logic [5:0]                tool
  );
    logic signed [DIFF_BITS-1:0] d;
    logic [5:0]                  first;
    axis_job_t                   j;
    j     = '0;
    d     = $signed({2'b00, want}) - $signed({2'b00, cur});
    first = d[DIFF_BITS-1] ? 6'h20 : 6'h1f;
    if (d == '0) begin
      j.cnt = 2'd0;
    end else if (d >= -32 && d <= 31) begin
      j.cnt    = 2'd1;
      j.cmd[0] = {opc, d[5:0]};
    end else if (d >= -64 && d <= 62) begin
      j.cnt    = 2'd2;
      j.cmd[0] = {opc, first};
      j.cmd[1] = {opc, d[5:0] - first};
    end else if (want == '0) begin
      j.cnt    = 2'd1;
      j.cmd[0] = {OPC_TOOL, tool};
    end else if (want[COORD_BITS_MAX-1:6] == '0) begin
      j.cnt    = 2'd2;
      j.cmd[0] = {OPC_DATA, want[5:0]};
      j.cmd[1] = {OPC_TOOL, tool};
    end else begin
      j.cnt    = 2'd3;
      j.cmd[0] = {OPC_DATA, want[COORD_BITS_MAX-1:6]};
      j.cmd[1] = {OPC_DATA, want[5:0]};
      j.cmd[2] = {OPC_TOOL, tool};
    end
    return j;
  endfunction

  // Coordinates are taken modulo the coordinate width.
  assign x_ext  = IN_BITS'(in_x);
  assign y_ext  = IN_BITS'(in_y);
  assign want_x = x_ext[COORD_BITS-1:0];
  assign want_y = y_ext[COORD_BITS-1:0];

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Classify the pixel against the current pen state.
  always_comb begin
    job.y    = axis_plan(COORD_BITS_MAX'(want_y), COORD_BITS_MAX'(ty_r), OPC_DY, TOOL_TARGETY);
    job.x    = axis_plan(COORD_BITS_MAX'(want_x), COORD_BITS_MAX'(tx_r), OPC_DX, TOOL_TARGETX);
    job.grey = in_colour;
    // The grey word c,c,c,ff needs two chunks for black, else five or six.
    if (grey_r == in_colour) begin
      job.g_cnt = 3'd0;
    end else if (in_colour == 8'd0) begin
      job.g_cnt = 3'd2;
    end else if (in_colour[7:6] != 2'b00) begin
      job.g_cnt = 3'd6;
    end else begin
      job.g_cnt = 3'd5;
    end
  end

  // Every move lands exactly on the wanted pixel, so the state follows the input.
  always_comb begin
    tx_nxt   = tx_r;
    ty_nxt   = ty_r;
    grey_nxt = grey_r;
    if (push) begin
      tx_nxt   = want_x;
      ty_nxt   = want_y;
      grey_nxt = in_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r   <= '0;
      ty_r   <= '0;
      grey_r <= 8'hff;
    end else begin
      tx_r   <= tx_nxt;
      ty_r   <= ty_nxt;
      grey_r <= grey_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pdce_queue.sv @@
// Short job queue between the front and back ends.
// Depends on pdce_pkg.
`default_nettype none

module pdce_queue
  import pdce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  pixel_job_t       push_job,
  output logic             full,
  input  wire logic        pop,
  output logic             head_valid,
  output pixel_job_t       head_job
);

  localparam int PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(Q_DEPTH + 1);

  pixel_job_t            entry_r [Q_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_BITS'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entry_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pdce_back.sv @@
// Back end: walks the head job and sends one command word per cycle unless stalled.
// Depends on pdce_pkg.
`default_nettype none

module pdce_back
  import pdce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  pixel_job_t       head_job,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_op_byte,
  output logic             out_last
);

  typedef enum logic [4:0] {
    PH_Y   = 5'b00001,
    PH_X   = 5'b00010,
    PH_G   = 5'b00100,
    PH_COL = 5'b01000,
    PH_END = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  phase_t      eff;
  logic [2:0]  idx_r, idx_nxt;
  logic [2:0]  cnt;
  logic [2:0]  chunk;
  logic [35:0] gval;
  logic        emit;
  cmd_t        cmd;
  logic        out_valid_r, out_valid_nxt;
  cmd_t        out_op_byte_r, out_op_byte_nxt;
  logic        out_last_r, out_last_nxt;

  // Skip the phases that have nothing to send for this pixel.
  always_comb begin
    case (phase_r)
      PH_Y: begin
        if (head_job.y.cnt != 2'd0) begin
          eff = PH_Y;
        end else if (head_job.x.cnt != 2'd0) begin
          eff = PH_X;
        end else if (head_job.g_cnt != 3'd0) begin
          eff = PH_G;
        end else begin
          eff = PH_END;
        end
      end
      PH_X: begin
        if (head_job.x.cnt != 2'd0) begin
          eff = PH_X;
        end else if (head_job.g_cnt != 3'd0) begin
          eff = PH_G;
        end else begin
          eff = PH_END;
        end
      end
      PH_G:    eff = (head_job.g_cnt != 3'd0) ? PH_G : PH_END;
      PH_COL:  eff = PH_COL;
      default: eff = PH_END;
    endcase
  end

  // Grey data word, most significant chunk first.
  assign gval  = {4'b0000, head_job.grey, head_job.grey, head_job.grey, 8'hff};
  assign chunk = head_job.g_cnt - 3'd1 - idx_r;

  // Word count of the active phase and the word to send.
  always_comb begin
    case (eff)
      PH_Y: begin
        cnt = 3'(head_job.y.cnt);
        cmd = head_job.y.cmd[idx_r[1:0]];
      end
      PH_X: begin
        cnt = 3'(head_job.x.cnt);
        cmd = head_job.x.cmd[idx_r[1:0]];
      end
      PH_G: begin
        cnt = head_job.g_cnt;
        case (chunk)
          3'd0:    cmd = {OPC_DATA, gval[5:0]};
          3'd1:    cmd = {OPC_DATA, gval[11:6]};
          3'd2:    cmd = {OPC_DATA, gval[17:12]};
          3'd3:    cmd = {OPC_DATA, gval[23:18]};
          3'd4:    cmd = {OPC_DATA, gval[29:24]};
          default: cmd = {OPC_DATA, gval[35:30]};
        endcase
      end
      PH_COL: begin
        cnt = 3'd1;
        cmd = CMD_COLOUR;
      end
      default: begin
        cnt = 3'd1;
        cmd = CMD_LAST;
      end
    endcase
  end

  assign emit = head_valid && (!out_valid_r || out_ready);
  assign pop  = emit && (eff == PH_END);

  // Step through the words of the active phase, then move to the next one.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (emit) begin
      if (idx_r != cnt - 3'd1) begin
        phase_nxt = eff;
        idx_nxt   = idx_r + 3'd1;
      end else begin
        idx_nxt = 3'd0;
        case (eff)
          PH_Y:    phase_nxt = PH_X;
          PH_X:    phase_nxt = PH_G;
          PH_G:    phase_nxt = PH_COL;
          PH_COL:  phase_nxt = PH_END;
          default: phase_nxt = PH_Y;
        endcase
      end
    end
  end

  // Output register: loads a new word whenever a job is waiting and the register is empty or being taken.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_op_byte_nxt = out_op_byte_r;
    out_last_nxt    = out_last_r;
    if (emit) begin
      out_valid_nxt   = 1'b1;
      out_op_byte_nxt = cmd;
      out_last_nxt    = (eff == PH_END);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_Y;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_op_byte_r <= out_op_byte_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_op_byte = out_op_byte_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

@@ rtl/pixel_to_draw_command_encoder.sv @@
// Pixel to draw-command encoder: each pixel becomes one to fourteen command words.
// Path: each accepted pixel is written into the job queue, and its words then pass through the output register.
// The back-end sequencer sends one command word per cycle while the output is not stalled; a
// two-entry job queue decouples it from the front end.
// Reset (synchronous, active low): pen at 0,0, grey level 255, queue and output empty.
`default_nettype none

module pixel_to_draw_command_encoder
  import pdce_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_x,
  input  wire logic [7:0] in_y,
  input  wire logic [7:0] in_colour,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_op_byte,
  output logic            out_last
);

  logic       q_full;
  logic       push;
  logic       pop;
  logic       head_valid;
  pixel_job_t push_job;
  pixel_job_t head_job;

  // Accept and classify pixels.
  pdce_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_colour (in_colour),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  // Decoupling queue.
  pdce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Send the command words.
  pdce_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_op_byte (out_op_byte),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

@@ rtl/pdce_chk.sv @@
// Port-level checker for the pixel to draw-command encoder, bound to the top level.
// Depends on pdce_pkg and pixel_to_draw_command_encoder_assert.svh.
`default_nettype none
`include "pixel_to_draw_command_encoder_assert.svh"

module pdce_chk
  import pdce_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_x,
  input wire logic [7:0] in_y,
  input wire logic [7:0] in_colour,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_op_byte,
  input wire logic       out_last
);

  // A stalled word holds.
  `PDCE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_op_byte) && $stable(out_last))

  // The zero vertical step appears exactly on the last word of a pixel.
  `PDCE_ASSERT(a_last_word, clk, rst_n, out_valid |-> ((out_op_byte == CMD_LAST) == out_last))

  // Tool words only select colour, target x or target y.
  `PDCE_ASSERT(a_tool_code, clk, rst_n, out_valid && out_op_byte[7:6] == OPC_TOOL |-> out_op_byte[5:0] == TOOL_COLOUR || out_op_byte[5:0] == TOOL_TARGETX || out_op_byte[5:0] == TOOL_TARGETY)

  // Reset empties the output.
  `PDCE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind pixel_to_draw_command_encoder pdce_chk u_chk (.*);

`default_nettype wire
